// ===== src/nearest_neighbour_tour_builder_unit_macros.svh =====
`ifndef NEAREST_NEIGHBOUR_TOUR_BUILDER_UNIT_MACROS_SVH
`define NEAREST_NEIGHBOUR_TOUR_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NNTB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nntb assertion failed");

// Next-cycle implication, checked outside reset.
`define NNTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nntb assertion failed");

`endif

// ===== src/nntb_pkg.sv =====
`timescale 1ns / 1ps

package nntb_pkg;

   localparam int CITY_W     = 6;
   localparam int COUNT_W    = 7;
   localparam int DIST_W     = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIST_W-1:0]  DIST_LIMIT       = 32'd99999999;
   localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = 7'd64;
   localparam logic [COUNT_W-1:0] CITY_COUNT_MIN   = 7'd2;

   localparam logic CSR_IDX_CITY_COUNT = 1'b0;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_BUILD = 1'b1;

   typedef struct packed {
      logic              func;
      logic [CITY_W-1:0] from_city;
      logic [CITY_W-1:0] to_city;
      logic [DIST_W-1:0] distance_value;
   } req_type;

   typedef struct packed {
      logic [CITY_W-1:0] city;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      STEP_IDLE      = 3'd0,
      STEP_INIT      = 3'd1,
      STEP_EMIT      = 3'd2,
      STEP_CHECK     = 3'd3,
      STEP_READ      = 3'd4,
      STEP_COMPARE   = 3'd5,
      STEP_MOVE      = 3'd6
   } step_type;

   typedef enum logic [2:0] {
      COND_NEVER     = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_NO_BUILD  = 3'd2,
      COND_OUT_BUSY  = 3'd3,
      COND_TOUR_DONE = 3'd4,
      COND_SCAN_MORE = 3'd5
   } cond_type;

   typedef struct packed {
      logic ready;
      logic clear;
      logic emit;
      logic scan_init;
      logic read;
      logic compare;
      logic move;
   } ctrl_type;

   typedef struct packed {
      logic build_accept;
      logic out_busy;
      logic tour_done;
      logic scan_more;
   } status_type;

   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      step_type target;
   } ucode_type;

endpackage

// ===== src/nntb_ram.sv =====
`timescale 1ns / 1ps

module nntb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/nntb_sequencer.sv =====
`timescale 1ns / 1ps

module nntb_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  nntb_pkg::status_type status,
   output nntb_pkg::ctrl_type   ctrl
);

   nntb_pkg::step_type  upc_ff;
   nntb_pkg::step_type  upc_in;
   nntb_pkg::ucode_type word;
   logic                jump;

   // Control store: one word per step.
   always_comb begin
      word = '0;
      case (upc_ff)
         nntb_pkg::STEP_IDLE: begin
            word.ctrl.ready = 1'b1;
            word.cond       = nntb_pkg::COND_NO_BUILD;
            word.target     = nntb_pkg::STEP_IDLE;
         end
         nntb_pkg::STEP_INIT: begin
            word.ctrl.clear = 1'b1;
            word.cond       = nntb_pkg::COND_NEVER;
            word.target     = nntb_pkg::STEP_IDLE;
         end
         nntb_pkg::STEP_EMIT: begin
            word.ctrl.emit = 1'b1;
            word.cond      = nntb_pkg::COND_OUT_BUSY;
            word.target    = nntb_pkg::STEP_EMIT;
         end
         nntb_pkg::STEP_CHECK: begin
            word.ctrl.scan_init = 1'b1;
            word.cond           = nntb_pkg::COND_TOUR_DONE;
            word.target         = nntb_pkg::STEP_IDLE;
         end
         nntb_pkg::STEP_READ: begin
            word.ctrl.read = 1'b1;
            word.cond      = nntb_pkg::COND_NEVER;
            word.target    = nntb_pkg::STEP_IDLE;
         end
         nntb_pkg::STEP_COMPARE: begin
            word.ctrl.compare = 1'b1;
            word.cond         = nntb_pkg::COND_SCAN_MORE;
            word.target       = nntb_pkg::STEP_READ;
         end
         nntb_pkg::STEP_MOVE: begin
            word.ctrl.move = 1'b1;
            word.cond      = nntb_pkg::COND_ALWAYS;
            word.target    = nntb_pkg::STEP_EMIT;
         end
         default: begin
            word.cond   = nntb_pkg::COND_ALWAYS;
            word.target = nntb_pkg::STEP_IDLE;
         end
      endcase
   end

   always_comb begin
      case (word.cond)
         nntb_pkg::COND_NEVER:     jump = 1'b0;
         nntb_pkg::COND_ALWAYS:    jump = 1'b1;
         nntb_pkg::COND_NO_BUILD:  jump = !status.build_accept;
         nntb_pkg::COND_OUT_BUSY:  jump = status.out_busy;
         nntb_pkg::COND_TOUR_DONE: jump = status.tour_done;
         nntb_pkg::COND_SCAN_MORE: jump = status.scan_more;
         default:                  jump = 1'b1;
      endcase
   end

   always_comb begin
      if (jump) begin
         upc_in = word.target;
      end else begin
         upc_in = nntb_pkg::step_type'(upc_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= nntb_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl = word.ctrl;

endmodule

// ===== src/nntb_datapath.sv =====
`timescale 1ns / 1ps

module nntb_datapath #(
   parameter int MAX_CITIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nntb_pkg::ctrl_type            ctrl,
   input  logic                          req_fire,
   input  nntb_pkg::req_type             req,
   input  logic [nntb_pkg::COUNT_W-1:0]  city_count,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output nntb_pkg::rsp_type             rsp,
   output nntb_pkg::status_type          status
);

   localparam int IDX_W  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int CNT_W  = $clog2(MAX_CITIES + 1);
   localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [IDX_W-1:0]            here_ff, here_in;
   logic [IDX_W-1:0]            best_ff, best_in;
   logic [nntb_pkg::DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            k_ff, k_in;
   logic [MAX_CITIES-1:0]       visited_ff, visited_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   nntb_pkg::rsp_type           rsp_ff, rsp_in;

   logic [nntb_pkg::COUNT_W-1:0] n_clamped;
   logic [CNT_W-1:0]             n;
   logic [IDX_W-1:0]             k_idx;
   logic                         out_busy;
   logic                         load_we;
   logic [ADDR_W-1:0]            wr_addr;
   logic [ADDR_W-1:0]            rd_addr;
   logic [nntb_pkg::DIST_W-1:0]  rd_data;

   always_comb begin
      if (city_count < nntb_pkg::CITY_COUNT_MIN) begin
         n_clamped = nntb_pkg::CITY_COUNT_MIN;
      end else if (city_count > nntb_pkg::COUNT_W'(MAX_CITIES)) begin
         n_clamped = nntb_pkg::COUNT_W'(MAX_CITIES);
      end else begin
         n_clamped = city_count;
      end
   end

   assign n        = CNT_W'(n_clamped);
   assign k_idx    = k_ff[IDX_W-1:0];
   assign out_busy = rsp_valid_ff && !rsp_ready;

   assign load_we = req_fire && (req.func == nntb_pkg::FUNC_LOAD)
                    && (nntb_pkg::COUNT_W'(req.from_city) < nntb_pkg::COUNT_W'(MAX_CITIES))
                    && (nntb_pkg::COUNT_W'(req.to_city) < nntb_pkg::COUNT_W'(MAX_CITIES));
   assign wr_addr = ADDR_W'(req.from_city[IDX_W-1:0]) * ADDR_W'(MAX_CITIES)
                    + ADDR_W'(req.to_city[IDX_W-1:0]);
   assign rd_addr = ADDR_W'(here_ff) * ADDR_W'(MAX_CITIES) + ADDR_W'(k_idx);

   nntb_ram #(
      .WIDTH (nntb_pkg::DIST_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (wr_addr),
      .wr_data (req.distance_value),
      .rd_en   (ctrl.read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      here_in      = here_ff;
      best_in      = best_ff;
      best_dist_in = best_dist_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      visited_in   = visited_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.clear) begin
         visited_in = '0;
         here_in    = '0;
         count_in   = '0;
      end
      if (ctrl.emit && !out_busy) begin
         rsp_valid_in        = 1'b1;
         rsp_in.city         = nntb_pkg::CITY_W'(here_ff);
         rsp_in.last         = (count_ff + 1'b1) == n;
         visited_in[here_ff] = 1'b1;
         count_in            = count_ff + 1'b1;
      end
      if (ctrl.scan_init) begin
         k_in         = '0;
         best_in      = '0;
         best_dist_in = nntb_pkg::DIST_LIMIT;
      end
      if (ctrl.compare) begin
         if (!visited_ff[k_idx] && (rd_data < best_dist_ff)) begin
            best_in      = k_idx;
            best_dist_in = rd_data;
         end
         k_in = k_ff + 1'b1;
      end
      if (ctrl.move) begin
         here_in = best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         visited_ff   <= '0;
         here_ff      <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         visited_ff   <= visited_in;
         here_ff      <= here_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      rsp_ff       <= rsp_in;
   end

   assign status.build_accept = req_fire && (req.func == nntb_pkg::FUNC_BUILD);
   assign status.out_busy     = out_busy;
   assign status.tour_done    = count_ff == n;
   assign status.scan_more    = (k_ff + 1'b1) < n;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/nearest_neighbour_tour_builder_unit.sv =====
// A load transaction writes one table entry and gives no result.
// A build transaction clears the tour and emits city 0 first; each further city follows the
// steps emit, scan setup, one read and one compare per entry, and move.
// A build holds the input until the last city is emitted; results may wait for rsp_ready.
// Synchronous reset clears the sequencer, the visited marks, the tour counters and the output
// valid and sets city_count to 64; the distance table is not cleared.
`timescale 1ns / 1ps

`include "nearest_neighbour_tour_builder_unit_macros.svh"

module nearest_neighbour_tour_builder_unit #(
   parameter int MAX_CITIES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  nntb_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output nntb_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nntb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [nntb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [nntb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   nntb_pkg::ctrl_type            ctrl;
   nntb_pkg::status_type          status;
   logic [nntb_pkg::COUNT_W-1:0]  city_count_ff, city_count_in;
   logic                          csr_index;
   logic                          csr_write;
   logic                          req_fire;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      city_count_in = city_count_ff;
      if (csr_write && (csr_index == nntb_pkg::CSR_IDX_CITY_COUNT)) begin
         city_count_in = csr_pwdata[nntb_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= nntb_pkg::CITY_COUNT_RESET;
      end else begin
         city_count_ff <= city_count_in;
      end
   end

   always_comb begin
      if (csr_index == nntb_pkg::CSR_IDX_CITY_COUNT) begin
         csr_prdata = nntb_pkg::CSR_DATA_W'(city_count_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign req_ready = ctrl.ready;
   assign req_fire  = req_valid && req_ready;

   nntb_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   nntb_datapath #(
      .MAX_CITIES (MAX_CITIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_fire   (req_fire),
      .req        (req_payload),
      .city_count (city_count_ff),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_payload),
      .status     (status)
   );

   `NNTB_ASSERT_NEXT(build_leaves_idle, clock, reset, status.build_accept, !req_ready)
   `NNTB_ASSERT_NEXT(tour_continues, clock, reset, rsp_valid && rsp_ready && !rsp_payload.last, !req_ready)
   `NNTB_ASSERT_IMPLY(idle_no_scan, clock, reset, req_ready, !ctrl.read && !ctrl.compare && !ctrl.emit)

endmodule
